// ===== design/lzpa_pkg.sv =====
// Shared types and constants for the lidar zone point averager.
// No dependencies; imported by every module of the block except lzpa_div.
package lzpa_pkg;

  localparam int ANGLE_W = 24;
  localparam int MEAN_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                      tick;
    logic                      zone;
    logic [15:0]               dist_mm;
    logic signed [ANGLE_W-1:0] angle;
  } lzpa_item_t;

  typedef struct packed {
    logic       push;
    lzpa_item_t item;
  } lzpa_push_t;

  typedef struct packed {
    logic       avail;
    lzpa_item_t item;
  } lzpa_head_t;

  localparam logic [1:0] REG_MIN_DISTANCE   = 2'd0;
  localparam logic [1:0] REG_MAX_DISTANCE   = 2'd1;
  localparam logic [1:0] REG_MIN_CONFIDENCE = 2'd2;

  localparam logic [15:0] MIN_DISTANCE_RST   = 16'd150;
  localparam logic [15:0] MAX_DISTANCE_RST   = 16'd400;
  localparam logic [7:0]  MIN_CONFIDENCE_RST = 8'd225;

  localparam logic [18:0] SPAN_BIAS = 19'd360000;
  localparam logic [18:0] SPAN_BASE = 19'd288000;
  localparam logic [17:0] TURN_1X   = 18'd36000;
  localparam logic [17:0] TURN_2X   = 18'd72000;
  localparam logic [17:0] TURN_3X   = 18'd108000;

  localparam logic [27:0] FULL_TURN_Q8    = 28'd9216000;
  localparam logic [27:0] HALF_TURN_Q8    = 28'd4608000;
  localparam logic [27:0] QUARTER_TURN_Q8 = 28'd2304000;
  localparam logic [27:0] FRONT_EDGE_Q8   = 28'd6912000;

  localparam logic [21:0] PI_MICRO = 22'd3141593;
  localparam logic [32:0] MRAD_DEN = 33'd4608000000;

endpackage

// ===== design/lzpa_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit QW bits.
// Depends on nothing; used by lzpa_back.
module lzpa_div #(
  parameter int NW = 58,
  parameter int DW = 46,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int W  = (NW > DW + QW) ? NW : DW + QW;
  localparam int IW = (QW > 1) ? $clog2(QW) : 1;

  logic [W-1:0]  rem;
  logic [W-1:0]  dsh;
  logic [IW-1:0] iter;
  logic          busy;
  logic          fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= W'(num);
        dsh  <= W'(den) << (QW - 1);
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quo  <= QW'({quo, fits});
        dsh  <= dsh >> 1;
        iter <= iter + 1'b1;
        if (iter == IW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lzpa_front.sv =====
// Front end: configuration registers, point filter and angle computation.
// Depends on lzpa_pkg; pushes classified items into lzpa_queue.
module lzpa_front #(
  parameter int FRAME_POINTS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [15:0]        point_distance,
  input  logic [7:0]         point_confidence,
  input  logic [15:0]        frame_start_angle,
  input  logic [15:0]        frame_end_angle,
  input  logic [3:0]         point_index,
  output lzpa_pkg::lzpa_push_t wr,
  input  logic               queue_full
);
  import lzpa_pkg::*;

  localparam int RK = 28;
  localparam longint unsigned RECIP_L = (64'd1 << RK) / (FRAME_POINTS - 1);
  localparam logic [RK:0] RECIP = (RK + 1)'(RECIP_L);
  localparam logic [5:0]  DIV_C = 6'(FRAME_POINTS - 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL1 = 3'd1;
  localparam logic [2:0] F_MUL2 = 3'd2;
  localparam logic [2:0] F_FIX  = 3'd3;
  localparam logic [2:0] F_MODH = 3'd4;
  localparam logic [2:0] F_MODL = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0]  state;
  logic [15:0] min_distance;
  logic [15:0] max_distance;
  logic [7:0]  min_confidence;

  logic        tick;
  logic [15:0] dist_mm;
  logic [15:0] start_ang;
  logic [3:0]  idx;
  logic [15:0] span;
  logic [19:0] prod;
  logic [2*RK:0] pm;
  logic [27:0] qv;
  logic [27:0] acc;

  logic [18:0] span_x;
  logic [18:0] span_y;
  logic [17:0] span_r;
  logic [15:0] span_c;
  logic        pass;
  logic [27:0] p8;
  logic [27:0] qe;
  logic [27:0] qd;
  logic [27:0] rem;
  logic [27:0] modh;
  logic [27:0] modl;
  logic [28:0] neg_ang;
  logic        keep;
  lzpa_item_t  item;

  assign in_stall = state != F_IDLE;

  always_comb begin
    span_x = 19'(frame_end_angle) + SPAN_BIAS - 19'(frame_start_angle);
    span_y = span_x - SPAN_BASE;
    span_r = span_y[17:0];
    if (span_r >= TURN_3X) begin
      span_c = 16'(span_r - TURN_3X);
    end else if (span_r >= TURN_2X) begin
      span_c = 16'(span_r - TURN_2X);
    end else if (span_r >= TURN_1X) begin
      span_c = 16'(span_r - TURN_1X);
    end else begin
      span_c = span_r[15:0];
    end
    pass = (point_distance > min_distance) && (point_distance < max_distance) &&
           (point_confidence > min_confidence);
  end

  always_comb begin
    p8  = {prod, 8'b0};
    qe  = pm[2*RK-1:RK];
    qd  = qe * 28'(DIV_C);
    rem = p8 - qd;
    modh = {4'b0, start_ang, 8'b0} + qv;
    for (int k = 4; k >= 2; k--) begin
      if (modh >= (FULL_TURN_Q8 << k)) begin
        modh = modh - (FULL_TURN_Q8 << k);
      end
    end
    modl = acc;
    for (int k = 1; k >= 0; k--) begin
      if (modl >= (FULL_TURN_Q8 << k)) begin
        modl = modl - (FULL_TURN_Q8 << k);
      end
    end
  end

  // acc holds the angle reduced into one turn
  always_comb begin
    neg_ang = {1'b0, acc} - {1'b0, FULL_TURN_Q8};
    item.tick    = tick;
    item.zone    = 1'b0;
    item.dist_mm = dist_mm;
    item.angle   = acc[ANGLE_W-1:0];
    keep         = tick;
    if (!tick) begin
      if (acc > FRONT_EDGE_Q8) begin
        keep       = 1'b1;
        item.angle = neg_ang[ANGLE_W-1:0];
      end else if (acc > QUARTER_TURN_Q8 && acc <= HALF_TURN_Q8) begin
        keep      = 1'b1;
        item.zone = 1'b1;
      end
    end
    wr.item = item;
    wr.push = (state == F_PUSH) && keep && !queue_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      min_distance   <= MIN_DISTANCE_RST;
      max_distance   <= MAX_DISTANCE_RST;
      min_confidence <= MIN_CONFIDENCE_RST;
      tick           <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MIN_DISTANCE:   min_distance   <= cfg_data;
          REG_MAX_DISTANCE:   max_distance   <= cfg_data;
          REG_MIN_CONFIDENCE: min_confidence <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            if (opcode) begin
              tick  <= 1'b1;
              state <= F_PUSH;
            end else if (pass) begin
              tick      <= 1'b0;
              dist_mm   <= point_distance;
              start_ang <= frame_start_angle;
              idx       <= point_index;
              span      <= span_c;
              state     <= F_MUL1;
            end
          end
        end
        F_MUL1: begin
          prod  <= 20'(span) * 20'(idx);
          state <= F_MUL2;
        end
        F_MUL2: begin
          pm    <= (2 * RK + 1)'(p8) * (2 * RK + 1)'(RECIP);
          state <= F_FIX;
        end
        F_FIX: begin
          qv    <= (rem >= 28'(DIV_C)) ? qe + 28'd1 : qe;
          state <= F_MODH;
        end
        F_MODH: begin
          acc   <= modh;
          state <= F_MODL;
        end
        F_MODL: begin
          acc   <= modl;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!keep || !queue_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lzpa_queue.sv =====
// Short queue between the front end and the accumulator back end.
// Depends on lzpa_pkg.
module lzpa_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  lzpa_pkg::lzpa_push_t wr,
  output logic                 full,
  output lzpa_pkg::lzpa_head_t head,
  input  logic                 pop
);
  import lzpa_pkg::*;

  lzpa_item_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr;
  logic [QUEUE_AW-1:0]   rptr;
  logic [QUEUE_AW:0]     fill;

  assign full       = fill == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign head.avail = fill != '0;
  assign head.item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr.push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (QUEUE_AW + 1)'(wr.push) - (QUEUE_AW + 1)'(pop);
    end
  end

endmodule

// ===== design/lzpa_back.sv =====
// Back end: zone accumulators and tick reporting through a shared divider.
// Depends on lzpa_pkg and lzpa_div; pops items from lzpa_queue.
module lzpa_back #(
  parameter int ZONE_CAPACITY = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lzpa_pkg::lzpa_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 zone,
  output logic [15:0]          mean_distance,
  output logic signed [12:0]   mean_angle_mrad,
  output logic [9:0]           point_count,
  output logic                 last
);
  import lzpa_pkg::*;

  localparam int CW   = $clog2(ZONE_CAPACITY + 1);
  localparam int CWX  = (CW > 10) ? CW : 10;
  localparam int DSW  = 16 + CW;
  localparam int ASW  = ANGLE_W + CW;
  localparam int AMW  = ANGLE_W - 1 + CW;
  localparam int NUMW = AMW + 22;
  localparam int DENW = 33 + CW;
  localparam logic [CW-1:0] CAP_C = CW'(ZONE_CAPACITY);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SEL  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_DDIV = 3'd3;
  localparam logic [2:0] B_ADIV = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]            state;
  logic                  zsel;
  logic [DSW-1:0]        f_dsum;
  logic signed [ASW-1:0] f_asum;
  logic [CW-1:0]         f_cnt;
  logic [DSW-1:0]        b_dsum;
  logic signed [ASW-1:0] b_asum;
  logic [CW-1:0]         b_cnt;

  logic [AMW-1:0]        mag;
  logic                  neg;
  logic [CW-1:0]         cnt_r;
  logic [NUMW-1:0]       anum;
  logic [DENW-1:0]       aden;
  logic [MEAN_W-1:0]     mean_d;

  logic [DSW-1:0]        sel_dsum;
  logic signed [ASW-1:0] sel_asum;
  logic signed [ASW-1:0] sel_abs;
  logic [CW-1:0]         sel_cnt;
  logic                  div_start;
  logic [NUMW-1:0]       div_num;
  logic [DENW-1:0]       div_den;
  logic                  div_done;
  logic [MEAN_W-1:0]     quo;
  logic signed [12:0]    ang;
  logic [CWX-1:0]        cnt_x;

  always_comb begin
    sel_dsum  = zsel ? b_dsum : f_dsum;
    sel_asum  = zsel ? b_asum : f_asum;
    sel_cnt   = zsel ? b_cnt : f_cnt;
    sel_abs   = sel_asum[ASW-1] ? -sel_asum : sel_asum;
    pop       = (state == B_IDLE) && head.avail;
    div_start = ((state == B_SEL) && (sel_cnt != '0)) || ((state == B_DDIV) && div_done);
    div_num   = (state == B_SEL) ? NUMW'(sel_dsum) : anum;
    div_den   = (state == B_SEL) ? DENW'(sel_cnt) : aden;
    ang       = {1'b0, quo[11:0]};
    cnt_x     = CWX'(cnt_r);
  end

  lzpa_div #(
    .NW (NUMW),
    .DW (DENW),
    .QW (MEAN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      zsel      <= 1'b0;
      out_valid <= 1'b0;
      f_dsum    <= '0;
      f_asum    <= '0;
      f_cnt     <= '0;
      b_dsum    <= '0;
      b_asum    <= '0;
      b_cnt     <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (head.avail) begin
            if (head.item.tick) begin
              zsel  <= 1'b0;
              state <= B_SEL;
            end else if (!head.item.zone) begin
              if (f_cnt < CAP_C) begin
                f_dsum <= f_dsum + DSW'(head.item.dist_mm);
                f_asum <= f_asum + ASW'(head.item.angle);
                f_cnt  <= f_cnt + 1'b1;
              end
            end else if (b_cnt < CAP_C) begin
              b_dsum <= b_dsum + DSW'(head.item.dist_mm);
              b_asum <= b_asum + ASW'(head.item.angle);
              b_cnt  <= b_cnt + 1'b1;
            end
          end
        end
        B_SEL: begin
          if (sel_cnt == '0) begin
            if (!zsel) begin
              zsel <= 1'b1;
            end else begin
              state <= B_IDLE;
            end
          end else begin
            mag   <= sel_abs[AMW-1:0];
            neg   <= sel_asum[ASW-1];
            cnt_r <= sel_cnt;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          anum  <= NUMW'(mag) * NUMW'(PI_MICRO);
          aden  <= DENW'(cnt_r) * DENW'(MRAD_DEN);
          state <= B_DDIV;
        end
        B_DDIV: begin
          if (div_done) begin
            mean_d <= quo;
            state  <= B_ADIV;
          end
        end
        B_ADIV: begin
          if (div_done) begin
            out_valid       <= 1'b1;
            zone            <= zsel;
            mean_distance   <= mean_d;
            mean_angle_mrad <= neg ? -ang : ang;
            point_count     <= cnt_x[9:0];
            last            <= zsel || (b_cnt == '0);
            state           <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (!zsel) begin
              f_dsum <= '0;
              f_asum <= '0;
              f_cnt  <= '0;
              zsel   <= 1'b1;
              state  <= B_SEL;
            end else begin
              b_dsum <= '0;
              b_asum <= '0;
              b_cnt  <= '0;
              state  <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lidar_zone_point_averager.sv =====
// Top level of the lidar zone point averager.
// Depends on lzpa_pkg, lzpa_front, lzpa_queue, lzpa_back (and lzpa_div).
//
// Input channel (in_valid/in_stall): opcode 0 carries one lidar point, opcode 1
// is a window tick. A transfer happens when in_valid is high and in_stall low.
// Points failing the distance/confidence filter are dropped at acceptance; a
// passing point occupies the front end (accept, two multiplies, quotient fix,
// two modulo steps, queue push) and no new item is taken until that push step is done.
// Ticks are queued behind earlier points through a 4-entry queue.
// Output channel (out_valid/out_stall): on a tick each zone holding points
// gives one result, front zone first; last marks the final one. Each result
// is made after the back end reaches the tick, by the shared 16-step divider
// run twice (mean distance, then mean angle).
// While out_stall is high the result register holds and the back end waits;
// the front keeps accepting until the queue fills, then raises in_stall.
// Configuration (cfg_write/cfg_index/cfg_data) is a single-cycle write.
// Synchronous reset restores register defaults and empties both zones.
module lidar_zone_point_averager #(
  parameter int FRAME_POINTS  = 12,
  parameter int ZONE_CAPACITY = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [15:0]        point_distance,
  input  logic [7:0]         point_confidence,
  input  logic [15:0]        frame_start_angle,
  input  logic [15:0]        frame_end_angle,
  input  logic [3:0]         point_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               zone,
  output logic [15:0]        mean_distance,
  output logic signed [12:0] mean_angle_mrad,
  output logic [9:0]         point_count,
  output logic               last
);
  import lzpa_pkg::*;

  lzpa_push_t wr;
  lzpa_head_t head;
  logic       queue_full;
  logic       pop;

  lzpa_front #(
    .FRAME_POINTS (FRAME_POINTS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .point_distance    (point_distance),
    .point_confidence  (point_confidence),
    .frame_start_angle (frame_start_angle),
    .frame_end_angle   (frame_end_angle),
    .point_index       (point_index),
    .wr                (wr),
    .queue_full        (queue_full)
  );

  lzpa_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  lzpa_back #(
    .ZONE_CAPACITY (ZONE_CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .zone            (zone),
    .mean_distance   (mean_distance),
    .mean_angle_mrad (mean_angle_mrad),
    .point_count     (point_count),
    .last            (last)
  );

endmodule

// ===== tb/tb_lidar_zone_point_averager.sv =====
// Self-checking testbench for lidar_zone_point_averager: directed table, then random
// windows of points closed by ticks, checked against an in-bench zone predictor.
// Depends on lzpa_pkg and the lidar_zone_point_averager top level.
module tb_lidar_zone_point_averager;
  import lzpa_pkg::*;

  localparam int FRAME_PTS     = 12;
  localparam int ZONE_CAP      = 512;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int TIMEOUT       = 3000000;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam int ZONE_FRONT = 0;
  localparam int ZONE_BACK  = 1;
  localparam int ZONE_ANY   = 2;

  localparam longint FULL_Q8    = 64'sd9216000;
  localparam longint HALF_Q8    = 64'sd4608000;
  localparam longint QUARTER_Q8 = 64'sd2304000;
  localparam longint PI_UMICRO  = 64'sd3141593;
  localparam longint MRAD_DIV   = 64'sd4608000000;

  typedef struct packed {
    logic               zone_id;
    logic [15:0]        avg_dist;
    logic signed [12:0] avg_mrad;
    logic [9:0]         n_pts;
    logic               is_last;
  } zone_mean_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] dist_mm;
    logic [7:0]  conf;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [3:0]  idx;
    logic        typed;
    logic [1:0]  n_typed;
    zone_mean_t  t0;
    zone_mean_t  t1;
  } lidar_item_t;

  localparam zone_mean_t NO_MEAN = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic zone;
  logic [15:0] mean_distance;
  logic signed [12:0] mean_angle_mrad;
  logic [9:0] point_count;
  logic last;

  lidar_item_t cur_item = '0;
  bit hold_off_req = 1'b0;
  bit sender_calm = 1'b0;
  int mismatch_cnt = 0;

  logic [15:0] lim_min_dist = MIN_DISTANCE_RST;
  logic [15:0] lim_max_dist = MAX_DISTANCE_RST;
  logic [7:0]  lim_min_conf = MIN_CONFIDENCE_RST;
  longint acc_dsum [2] = '{0, 0};
  longint acc_asum [2] = '{0, 0};
  int     acc_cnt  [2] = '{0, 0};
  zone_mean_t step_out[$];
  zone_mean_t pending_means[$];

  always #2 clk = ~clk;

  lidar_zone_point_averager #(
    .FRAME_POINTS (FRAME_PTS),
    .ZONE_CAPACITY(ZONE_CAP)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (cur_item.opcode),
    .point_distance   (cur_item.dist_mm),
    .point_confidence (cur_item.conf),
    .frame_start_angle(cur_item.start_ang),
    .frame_end_angle  (cur_item.end_ang),
    .point_index      (cur_item.idx),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .zone             (zone),
    .mean_distance    (mean_distance),
    .mean_angle_mrad  (mean_angle_mrad),
    .point_count      (point_count),
    .last             (last)
  );

  function automatic longint frame_angle_q8(longint s, longint e, longint i);
    longint span;
    longint a;
    span = (e + 360000 - s) % 36000;
    a = s * 256 + (span * i * 256) / (FRAME_PTS - 1);
    a = a % FULL_Q8;
    if (a > HALF_Q8) a = a - FULL_Q8;
    return a;
  endfunction

  function automatic logic signed [12:0] mrad_of_sum(longint sum, longint cnt);
    longint mag;
    longint q;
    mag = (sum < 0) ? -sum : sum;
    q = (mag * PI_UMICRO) / (MRAD_DIV * cnt);
    if (sum < 0) q = -q;
    return q[12:0];
  endfunction

  // Updates the zone accumulators; a tick leaves its results in step_out.
  function automatic void averager_step(input lidar_item_t it);
    longint a;
    int z;
    zone_mean_t m;
    step_out.delete();
    if (it.opcode == OP_POINT) begin
      if (it.dist_mm > lim_min_dist && it.dist_mm < lim_max_dist &&
          it.conf > lim_min_conf) begin
        a = frame_angle_q8(longint'(it.start_ang), longint'(it.end_ang), longint'(it.idx));
        z = -1;
        if (a < 0 && a > -QUARTER_Q8) z = ZONE_FRONT;
        else if (a > QUARTER_Q8) z = ZONE_BACK;
        if (z >= 0 && acc_cnt[z] < ZONE_CAP) begin
          acc_dsum[z] += longint'(it.dist_mm);
          acc_asum[z] += a;
          acc_cnt[z]++;
        end
      end
    end else begin
      for (int zz = 0; zz < 2; zz++) begin
        if (acc_cnt[zz] > 0) begin
          m.zone_id  = (zz == ZONE_BACK);
          m.avg_dist = 16'(acc_dsum[zz] / acc_cnt[zz]);
          m.avg_mrad = mrad_of_sum(acc_asum[zz], longint'(acc_cnt[zz]));
          m.n_pts    = 10'(acc_cnt[zz]);
          m.is_last  = (zz == ZONE_BACK) || (acc_cnt[ZONE_BACK] == 0);
          step_out.push_back(m);
          acc_dsum[zz] = 0;
          acc_asum[zz] = 0;
          acc_cnt[zz]  = 0;
        end
      end
    end
  endfunction

  function automatic void flag_mismatch(string what, zone_mean_t want, zone_mean_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display({"%s: exp zone=%0d dist=%0d mrad=%0d cnt=%0d last=%0d",
                " | got zone=%0d dist=%0d mrad=%0d cnt=%0d last=%0d"},
               what, want.zone_id, want.avg_dist, want.avg_mrad, want.n_pts, want.is_last,
               got.zone_id, got.avg_dist, got.avg_mrad, got.n_pts, got.is_last);
  endfunction

  always @(posedge clk) begin : monitor
    zone_mean_t got;
    zone_mean_t want;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MIN_DISTANCE:   lim_min_dist = cfg_data;
          REG_MAX_DISTANCE:   lim_max_dist = cfg_data;
          REG_MIN_CONFIDENCE: lim_min_conf = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        averager_step(cur_item);
        if (cur_item.typed) begin
          if (cur_item.n_typed > 0) pending_means.push_back(cur_item.t0);
          if (cur_item.n_typed > 1) pending_means.push_back(cur_item.t1);
        end else begin
          foreach (step_out[k]) pending_means.push_back(step_out[k]);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{zone, mean_distance, mean_angle_mrad, point_count, last};
        if (pending_means.size() == 0) begin
          flag_mismatch("result with none pending", NO_MEAN, got);
        end else begin
          want = pending_means.pop_front();
          if (got !== want) flag_mismatch("zone mean mismatch", want, got);
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Receiver: random stall runs, plus one long hold-off on request.
  initial begin : rx_side
    bit stalling;
    int run_left;
    stalling = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling) run_left = gap_len() + 1;
        else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(40, 150);
        else run_left = $urandom_range(1, 8);
      end
      run_left--;
      out_stall = stalling;
    end
  end

  function automatic lidar_item_t mk(logic op, logic [15:0] d, logic [7:0] c,
                                     logic [15:0] s, logic [15:0] e, logic [3:0] i);
    lidar_item_t it;
    it = '0;
    it.opcode    = op;
    it.dist_mm   = d;
    it.conf      = c;
    it.start_ang = s;
    it.end_ang   = e;
    it.idx       = i;
    return it;
  endfunction

  function automatic lidar_item_t tick_typed(logic [1:0] n, zone_mean_t r0, zone_mean_t r1);
    lidar_item_t it;
    it = mk(OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    it.typed   = 1'b1;
    it.n_typed = n;
    it.t0      = r0;
    it.t1      = r1;
    return it;
  endfunction

  function automatic lidar_item_t random_point(int bias);
    lidar_item_t it;
    int aim;
    it = mk(OP_POINT, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
            4'($urandom));
    if (bias == ZONE_ANY && $urandom_range(0, 4) == 0) return it;
    if ({1'b0, lim_max_dist} > {1'b0, lim_min_dist} + 17'd1)
      it.dist_mm = 16'($urandom_range(lim_min_dist + 1, lim_max_dist - 1));
    if (lim_min_conf != 8'hFF)
      it.conf = 8'($urandom_range(lim_min_conf + 1, 255));
    aim = (bias == ZONE_ANY) ? $urandom_range(0, 2) : bias;
    case (aim)
      ZONE_FRONT: it.start_ang = 16'($urandom_range(27001, 35999));
      ZONE_BACK:  it.start_ang = 16'($urandom_range(9001, 18000));
      default:    it.start_ang = 16'($urandom_range(0, 35999));
    endcase
    if (aim == ZONE_ANY) begin
      it.end_ang = 16'($urandom_range(0, 35999));
      it.idx     = 4'($urandom_range(0, 11));
    end else begin
      it.end_ang = 16'((it.start_ang + $urandom_range(0, 400)) % 36000);
    end
    return it;
  endfunction

  task automatic offer(input lidar_item_t it);
    int gap;
    gap = sender_calm ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid, waits for all pending means, then lets the pipeline drain.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [7:0] conf);
    wait_quiet();
    write_reg(REG_MIN_DISTANCE, lo);
    write_reg(REG_MAX_DISTANCE, hi);
    write_reg(REG_MIN_CONFIDENCE, {8'd0, conf});
  endtask

  task automatic send_window(input int npts, input int bias);
    for (int k = 0; k < npts; k++) offer(random_point(bias));
    offer(mk(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
             4'($urandom)));
    if ($urandom_range(0, 9) == 0) offer(mk(OP_TICK, '0, '0, '0, '0, '0));
  endtask

  task automatic run_windows(input int n);
    for (int k = 0; k < n; k++) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) send_window($urandom_range(20, 40), ZONE_ANY);
      else send_window($urandom_range(0, 10), ZONE_ANY);
    end
    sender_calm = 1'b0;
  endtask

  initial begin : stimulus
    lidar_item_t dir_tab[$];
    logic [15:0] lo;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    dir_tab.push_back(tick_typed(2'd0, NO_MEAN, NO_MEAN));
    dir_tab.push_back(mk(OP_POINT, 16'd200, 8'd230, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd300, 8'd230, 16'd18000, 16'd18000, 4'd0));
    dir_tab.push_back(tick_typed(2'd2, '{1'b0, 16'd200, -13'sd174, 10'd1, 1'b0},
                                       '{1'b1, 16'd300, 13'sd3141, 10'd1, 1'b1}));
    dir_tab.push_back(tick_typed(2'd0, NO_MEAN, NO_MEAN));
    dir_tab.push_back(mk(OP_POINT, 16'd150, 8'd230, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd400, 8'd230, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd200, 8'd225, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd151, 8'd226, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd399, 8'd255, 16'd35000, 16'd35000, 4'd0));
    dir_tab.push_back(tick_typed(2'd1, '{1'b0, 16'd275, -13'sd174, 10'd2, 1'b1}, NO_MEAN));
    dir_tab.push_back(mk(OP_POINT, 16'd0, 8'd0, 16'd0, 16'd0, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'hFFFF, 8'hFF, 16'd35000, 16'd35000, 4'd0));
    // exact zone edges at -90 and +90 degrees
    dir_tab.push_back(mk(OP_POINT, 16'd200, 8'd230, 16'd27000, 16'd27000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd200, 8'd230, 16'd9000, 16'd9000, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd250, 8'd240, 16'd9001, 16'd9001, 4'd0));
    dir_tab.push_back(mk(OP_POINT, 16'd260, 8'd240, 16'd34000, 16'd35100, 4'd15));
    dir_tab.push_back(mk(OP_POINT, 16'd300, 8'd240, 16'hFFFF, 16'd0, 4'd15));
    dir_tab.push_back(mk(OP_POINT, 16'd310, 8'd240, 16'd0, 16'hFFFF, 4'd11));
    dir_tab.push_back(mk(OP_POINT, 16'd320, 8'd240, 16'd35999, 16'd0, 4'd11));
    dir_tab.push_back(mk(OP_TICK, 16'd0, 8'd0, 16'd0, 16'd0, 4'd0));
    dir_tab.push_back(mk(OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
    foreach (dir_tab[k]) offer(dir_tab[k]);

    set_limits(16'd0, 16'hFFFF, 8'd0);
    run_windows(12);
    // overfill the front zone past its capacity
    send_window(540, ZONE_FRONT);

    repeat (4) begin
      lo = 16'($urandom_range(0, 2000));
      set_limits(lo, 16'(lo + $urandom_range(2, 30000)), 8'($urandom_range(0, 254)));
      run_windows(12);
    end

    set_limits(16'hFFFF, 16'd0, 8'hFF);
    run_windows(5);

    set_limits(MIN_DISTANCE_RST, MAX_DISTANCE_RST, MIN_CONFIDENCE_RST);
    hold_off_req = 1'b1;
    sender_calm = 1'b1;
    repeat (8) send_window(3, ZONE_FRONT);
    sender_calm = 1'b0;
    run_windows(12);

    wait_quiet();
    if (mismatch_cnt == 0 && pending_means.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lzpa_pkg.sv
design/lzpa_div.sv
design/lzpa_front.sv
design/lzpa_queue.sv
design/lzpa_back.sv
design/lidar_zone_point_averager.sv
tb/tb_lidar_zone_point_averager.sv
